### sv/cfr_pkg.sv
// Shared types, codes and the CRC-16 byte update for the command frame receiver.
// No dependencies; every other file imports this package.
package cfr_pkg;

  localparam int FRAME_BYTES = 7;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0]  FRAME_LEN    = 3'd7;
  localparam logic [2:0]  LAST_INDEX   = 3'd6;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [7:0]  EMPTY_HEADER = 8'hFF;

  localparam logic REQ_BYTE  = 1'b0;
  localparam logic REQ_FETCH = 1'b1;

  localparam logic [1:0] STATUS_NONE = 2'd0;
  localparam logic [1:0] STATUS_GOOD = 2'd1;
  localparam logic [1:0] STATUS_BAD  = 2'd2;

  typedef enum logic [1:0] {
    KIND_FRAME,
    KIND_DROP,
    KIND_FETCH
  } cfr_kind_t;

  typedef struct packed {
    cfr_kind_t                         kind;
    logic [FRAME_BYTES-1:0][7:0]       bytes;
    logic                              crc_ok;
  } cfr_entry_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

### sv/cfr_front.sv
// Front end: accepts requests, assembles seven-byte frames and runs the CRC.
// Emits one queue entry per finished frame or fetch. Depends on cfr_pkg.
module cfr_front import cfr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  logic       req_type,
  input  logic [7:0] rx_byte,
  output logic       push_valid,
  input  logic       push_ready,
  output cfr_entry_t push_entry
);

  logic [2:0]  byte_count;
  logic [2:0]  byte_count_next;
  logic [15:0] running_crc;
  logic [15:0] running_crc_next;
  logic [2:0]  count_eff;
  logic [15:0] crc_eff;
  logic [15:0] crc_new;
  logic        last_byte;
  logic        take_byte;
  logic [7:0]  asm_bytes [FRAME_BYTES-1];

  assign req_ready = push_ready;
  assign take_byte = req_valid && req_ready && (req_type == REQ_BYTE);

  always_comb begin
    count_eff = (byte_count == FRAME_LEN) ? 3'd0 : byte_count;
    crc_eff   = (byte_count == FRAME_LEN) ? CRC_INIT : running_crc;
    crc_new   = crc_byte(crc_eff, rx_byte);
    last_byte = (count_eff == LAST_INDEX);

    push_valid = req_valid && ((req_type == REQ_FETCH) || last_byte);
    for (int i = 0; i < FRAME_BYTES - 1; i++) begin
      push_entry.bytes[i] = asm_bytes[i];
    end
    push_entry.bytes[FRAME_BYTES-1] = rx_byte;
    push_entry.crc_ok = (crc_new == 16'h0000);
    if (req_type == REQ_FETCH) begin
      push_entry.kind = KIND_FETCH;
    end else if (asm_bytes[0] == EMPTY_HEADER) begin
      push_entry.kind = KIND_DROP;
    end else begin
      push_entry.kind = KIND_FRAME;
    end

    byte_count_next  = byte_count;
    running_crc_next = running_crc;
    if (take_byte) begin
      if (last_byte) begin
        byte_count_next  = 3'd0;
        running_crc_next = CRC_INIT;
      end else begin
        byte_count_next  = count_eff + 3'd1;
        running_crc_next = crc_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= 3'd0;
      running_crc <= CRC_INIT;
    end else begin
      byte_count  <= byte_count_next;
      running_crc <= running_crc_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < FRAME_BYTES - 1; i++) begin
      if (take_byte && !last_byte && (count_eff == 3'(i))) begin
        asm_bytes[i] <= rx_byte;
      end
    end
  end

endmodule

### sv/cfr_queue.sv
// Two-entry queue that decouples the front end from the back end.
// Holds cfr_entry_t items in arrival order. Depends on cfr_pkg.
module cfr_queue import cfr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  cfr_entry_t push_entry,
  output logic       pop_valid,
  input  logic       pop_ready,
  output cfr_entry_t pop_entry
);

  cfr_entry_t entries [QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'(QUEUE_DEPTH));
  assign pop_valid  = (count != 2'd0);
  assign pop_entry  = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

endmodule

### sv/cfr_back.sv
// Back end: keeps the one-frame slot and answers fetches from a response register.
// Consumes entries from cfr_queue. Depends on cfr_pkg.
module cfr_back import cfr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  cfr_entry_t         pop_entry,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic [1:0]         status,
  output logic [7:0]         header,
  output logic signed [7:0]  turn_right,
  output logic signed [7:0]  forward_speed,
  output logic [15:0]        duration,
  output logic [15:0]        check_word
);

  logic [FRAME_BYTES-1:0][7:0] slot_bytes;
  logic                        slot_crc_ok;
  logic                        slot_valid;
  logic                        do_pop;

  assign pop_ready = (pop_entry.kind != KIND_FETCH) || !rsp_valid || rsp_ready;
  assign do_pop    = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid  <= 1'b0;
      slot_crc_ok <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (do_pop) begin
        case (pop_entry.kind)
          KIND_FRAME: begin
            slot_valid  <= 1'b1;
            slot_crc_ok <= pop_entry.crc_ok;
          end
          KIND_DROP: begin
            slot_valid <= 1'b0;
          end
          KIND_FETCH: begin
            slot_valid <= 1'b0;
            rsp_valid  <= 1'b1;
          end
          default: begin
            slot_valid <= slot_valid;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop && (pop_entry.kind == KIND_FRAME)) begin
      slot_bytes <= pop_entry.bytes;
    end
    if (do_pop && (pop_entry.kind == KIND_FETCH)) begin
      if (slot_valid) begin
        status        <= slot_crc_ok ? STATUS_GOOD : STATUS_BAD;
        header        <= slot_bytes[0];
        turn_right    <= slot_bytes[1];
        forward_speed <= slot_bytes[2];
        duration      <= {slot_bytes[3], slot_bytes[4]};
        check_word    <= {slot_bytes[5], slot_bytes[6]};
      end else begin
        status        <= STATUS_NONE;
        header        <= 8'h00;
        turn_right    <= 8'sh00;
        forward_speed <= 8'sh00;
        duration      <= 16'h0000;
        check_word    <= 16'h0000;
      end
    end
  end

endmodule

### sv/command_frame_receiver_top.sv
// Top level of the command frame receiver: front end, queue and back end.
// Depends on cfr_pkg, cfr_front, cfr_queue and cfr_back.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------------------
//   request | req_valid, req_ready | req_type, rx_byte
//   response| rsp_valid, rsp_ready | status, header, turn_right, forward_speed,
//           |                      | duration, check_word
//
// One request is taken per cycle while req_ready is high; a taken fetch passes
// the queue, then raises rsp_valid, delayed further only while a response waits.
// The request side, bytes included, stalls only when the two-entry queue is full,
// which happens while an unconsumed response blocks a following fetch.
// Reset clears the byte counter, CRC, slot state, queue and response valid.
module command_frame_receiver_top import cfr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic               req_type,
  input  logic [7:0]         rx_byte,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic [1:0]         status,
  output logic [7:0]         header,
  output logic signed [7:0]  turn_right,
  output logic signed [7:0]  forward_speed,
  output logic [15:0]        duration,
  output logic [15:0]        check_word
);

  logic       push_valid;
  logic       push_ready;
  cfr_entry_t push_entry;
  logic       pop_valid;
  logic       pop_ready;
  cfr_entry_t pop_entry;

  cfr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req_type   (req_type),
    .rx_byte    (rx_byte),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  cfr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  cfr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_entry     (pop_entry),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .status        (status),
    .header        (header),
    .turn_right    (turn_right),
    .forward_speed (forward_speed),
    .duration      (duration),
    .check_word    (check_word)
  );

endmodule
